// ===== rtl/core/lrt_pkg.sv =====
// Shared types and constants for the timestamp LRU replacement block.
package lrt_pkg;

	localparam int STAMP_W   = 64;
	localparam int SET_IN_W  = 10;
	localparam int WAY_IN_W  = 4;
	localparam int MAX_SET_W = 16;
	localparam int MAX_WAY_W = 5;

	typedef enum logic {
		MODE_VICTIM = 1'b0,
		MODE_UPDATE = 1'b1
	} lrt_mode_t;

	// One access to the stamp store: row clear, way write or row read.
	typedef struct packed {
		logic                 rd;
		logic                 wr;
		logic                 clr;
		logic [MAX_SET_W-1:0] set;
		logic [MAX_WAY_W-1:0] way;
	} lrt_mem_cmd_t;

endpackage

// ===== rtl/core/lrt_set_map.sv =====
// Two-stage reduction of the raw set index modulo SETS.
module lrt_set_map
	import lrt_pkg::*;
#(
	parameter int SETS  = 1024,
	parameter int SET_W = 10
) (
	input  logic                clk,
	input  logic [SET_IN_W-1:0] x,
	output logic [SET_W-1:0]    set_s2
);

	if (SETS <= 1024) begin : g_mod
		// q = floor(x * ceil(2^20 / SETS) / 2^20) is exact for x < 1024
		localparam int          K     = 20;
		localparam logic [20:0] RECIP = 21'((2**K + SETS - 1) / SETS);

		logic [30:0]         prod;
		logic [SET_IN_W-1:0] q_s1;
		logic [SET_IN_W-1:0] x_s1;
		logic [20:0]         back;
		logic [20:0]         rem;

		assign prod = 31'(x) * 31'(RECIP);
		assign back = 21'(q_s1) * 21'(SETS);
		assign rem  = 21'(x_s1) - back;

		always_ff @(posedge clk) begin
			q_s1   <= prod[K+SET_IN_W-1:K];
			x_s1   <= x;
			set_s2 <= rem[SET_W-1:0];
		end
	end else begin : g_pass
		// index is always below SETS; keep the same x_s1 and set_s2 register timing
		logic [SET_IN_W-1:0] x_s1;

		always_ff @(posedge clk) begin
			x_s1   <= x;
			set_s2 <= SET_W'(x_s1);
		end
	end

endmodule

// ===== rtl/core/lrt_stamp_mem.sv =====
// Stamp store: one row of WAYS stamps per set, row clear, per-way write, registered row read.
module lrt_stamp_mem
	import lrt_pkg::*;
#(
	parameter int SETS  = 1024,
	parameter int WAYS  = 16,
	parameter int SET_W = 10,
	parameter int WAY_W = 4
) (
	input  logic                             clk,
	input  lrt_mem_cmd_t                     cmd,
	input  logic [STAMP_W-1:0]               wdata,
	output logic [WAYS-1:0][STAMP_W-1:0]     rd_row
);

	logic [WAYS-1:0][STAMP_W-1:0] stamp_mem [SETS];
	logic [SET_W-1:0]             addr;
	logic [WAY_W-1:0]             way;

	assign addr = cmd.set[SET_W-1:0];
	assign way  = cmd.way[WAY_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			stamp_mem[addr] <= '0;
		end else if (cmd.wr) begin
			stamp_mem[addr][way] <= wdata;
		end
		if (cmd.rd) begin
			rd_row <= stamp_mem[addr];
		end
	end

endmodule

// ===== rtl/core/lrt_min_tree.sv =====
// Registered min-stamp tree over one row; ties resolve to the lower way.
module lrt_min_tree
	import lrt_pkg::*;
#(
	parameter int WAYS  = 16,
	parameter int WAY_W = 4
) (
	input  logic                         clk,
	input  logic [WAYS-1:0][STAMP_W-1:0] row,
	output logic [WAY_W-1:0]             root_way
);

	localparam int LVL   = $clog2(WAYS);
	localparam int LEAF  = 1 << LVL;
	localparam int NODES = LEAF - 1;
	localparam int ALL   = 2 * LEAF - 1;

	logic [STAMP_W-1:0] all_stamp [ALL];
	logic [WAY_W-1:0]   all_way   [ALL];
	logic               all_vld   [ALL];

	logic [STAMP_W-1:0] node_stamp_q [NODES];
	logic [WAY_W-1:0]   node_way_q   [NODES];
	logic               node_vld_q   [NODES];

	// heap layout: internal nodes first, leaves after; left child holds lower ways
	always_comb begin
		for (int c = 0; c < NODES; c++) begin
			all_stamp[c] = node_stamp_q[c];
			all_way[c]   = node_way_q[c];
			all_vld[c]   = node_vld_q[c];
		end
		for (int j = 0; j < WAYS; j++) begin
			all_stamp[NODES+j] = row[j];
			all_way[NODES+j]   = WAY_W'(j);
			all_vld[NODES+j]   = 1'b1;
		end
		for (int j = WAYS; j < LEAF; j++) begin
			all_stamp[NODES+j] = '0;
			all_way[NODES+j]   = '0;
			all_vld[NODES+j]   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NODES; i++) begin
			node_vld_q[i] <= all_vld[2*i+1] || all_vld[2*i+2];
			if (all_vld[2*i+2] &&
			    (!all_vld[2*i+1] || (all_stamp[2*i+2] < all_stamp[2*i+1]))) begin
				node_stamp_q[i] <= all_stamp[2*i+2];
				node_way_q[i]   <= all_way[2*i+2];
			end else begin
				node_stamp_q[i] <= all_stamp[2*i+1];
				node_way_q[i]   <= all_way[2*i+1];
			end
		end
	end

	assign root_way = node_way_q[0];

endmodule

// ===== rtl/core/lru_timestamp_replacement.sv =====
// Timestamp LRU replacement: victim search and stamp update over a row-wide stamp store.
// Victim request: the set index is reduced in lrt_set_map, the row is read in S_ISSUE, the
//   min tree settles one level per cycle in S_TREE, then victim_way registers with done.
// Update request: no result; busy through S_MAP and S_ISSUE. No new request is taken until S_IDLE.
// Reset (arst_n low, asynchronous) starts a clearing pass over all SETS rows, one row per
//   cycle, with busy high; the receiver cannot stall, each done strobe shows for one cycle.
module lru_timestamp_replacement
	import lrt_pkg::*;
#(
	parameter int SETS = 1024,
	parameter int WAYS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [SET_IN_W-1:0] set_index,
	input  logic [WAY_IN_W-1:0] way_index,
	input  logic                was_hit,
	input  logic                is_writeback,
	input  logic [STAMP_W-1:0]  now,
	output logic                done,
	output logic [WAY_IN_W-1:0] victim_way
);

	localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W    = $clog2(WAYS);
	localparam int TREE_LVL = $clog2(WAYS);
	localparam int CNT_W    = $clog2(TREE_LVL + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MAP,
		S_ISSUE,
		S_TREE
	} state_t;

	state_t                       state_q;
	logic [SET_W-1:0]             clr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         accept;

	// request fields held for the duration of the transfer
	logic                         mode_q;
	logic [WAY_IN_W-1:0]          way_q;
	logic                         hit_q;
	logic                         wb_q;
	logic [STAMP_W-1:0]           now_q;

	logic [SET_W-1:0]             set_s2;
	lrt_mem_cmd_t                 mem_cmd;
	logic [WAYS-1:0][STAMP_W-1:0] rd_row;
	logic [WAY_W-1:0]             root_way;
	logic                         upd_ok;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// ways beyond WAYS are dropped; a writeback hit keeps the old stamp
	assign upd_ok = (6'(way_q) < 6'(WAYS)) && !(hit_q && wb_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			way_q  <= way_index;
			hit_q  <= was_hit;
			wb_q   <= is_writeback;
			now_q  <= now;
		end
	end

	// set index reduction runs every cycle; its output is valid in S_ISSUE
	lrt_set_map #(
		.SETS  (SETS),
		.SET_W (SET_W)
	) u_set_map (
		.clk    (clk),
		.x      (set_index),
		.set_s2 (set_s2)
	);

	// store access: clearing sweep, then one read per victim request or at most one way write per update
	always_comb begin
		mem_cmd     = '0;
		mem_cmd.way = MAX_WAY_W'(way_q);
		case (state_q)
			S_CLEAR: begin
				mem_cmd.clr = 1'b1;
				mem_cmd.set = MAX_SET_W'(clr_q);
			end
			S_ISSUE: begin
				mem_cmd.set = MAX_SET_W'(set_s2);
				mem_cmd.rd  = (mode_q == MODE_VICTIM);
				mem_cmd.wr  = (mode_q == MODE_UPDATE) && upd_ok;
			end
			default: begin
				mem_cmd = mem_cmd;
			end
		endcase
	end

	lrt_stamp_mem #(
		.SETS  (SETS),
		.WAYS  (WAYS),
		.SET_W (SET_W),
		.WAY_W (WAY_W)
	) u_stamp_mem (
		.clk    (clk),
		.cmd    (mem_cmd),
		.wdata  (now_q),
		.rd_row (rd_row)
	);

	// one tree level settles per cycle after the row lands
	lrt_min_tree #(
		.WAYS  (WAYS),
		.WAY_W (WAY_W)
	) u_min_tree (
		.clk      (clk),
		.row      (rd_row),
		.root_way (root_way)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cnt_q      <= '0;
			done       <= 1'b0;
			victim_way <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					cnt_q <= '0;
					if (mode_q == MODE_VICTIM) begin
						state_q <= S_TREE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_TREE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TREE_LVL)) begin
						// root holds the winner; ways above 15 report their low 4 bits
						victim_way <= WAY_IN_W'(root_way);
						done       <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/lrt_checker.sv =====
// Port-level checks on request/result timing, bound to the top level.
module lrt_port_assert
	import lrt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic done
);

	// a result strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a transfer always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after an accepted request");

	// a result comes exactly as the block frees up
	a_done_at_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done without the block finishing a request");

	// updates produce no result
	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_UPDATE)) |=> !done ##1 !done ##1 !done)
		else $error("result strobe after an update request");

endmodule

bind lru_timestamp_replacement lrt_port_assert u_lrt_checker (.*);
